FILE: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the single-wire bus master
// Transaction payloads, command codes, register indexes and phase encoding.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // Command codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_PRE_RESET_HIGH = 3'd0;
    localparam logic [2:0] CFG_RESET_LOW      = 3'd1;
    localparam logic [2:0] CFG_RESET_WAIT     = 3'd2;
    localparam logic [2:0] CFG_SLOT           = 3'd3;
    localparam logic [2:0] CFG_SHORT          = 3'd4;
    localparam logic [2:0] CFG_POST_WRITE     = 3'd5;

    // Configuration reset values
    localparam logic [15:0] RST_PRE_RESET_HIGH = 16'd100;
    localparam logic [15:0] RST_RESET_LOW      = 16'd600;
    localparam logic [15:0] RST_RESET_WAIT     = 16'd240;
    localparam logic [15:0] RST_SLOT           = 16'd60;
    localparam logic [7:0]  RST_SHORT          = 8'd2;
    localparam logic [15:0] RST_POST_WRITE     = 16'd30;

    // Bus phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RST_PRE  = 7'b0000010,
        PH_RST_LOW  = 7'b0000100,
        PH_RST_WAIT = 7'b0001000,
        PH_BIT_LOW  = 7'b0010000,
        PH_BIT_HIGH = 7'b0100000,
        PH_GAP      = 7'b1000000
    } t_phase;

    // Input transaction
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       op_done;
        logic [7:0] read_data;
        logic       cmd_rejected;
    } t_out;

endpackage

FILE: rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: single-wire bus master with reset, write and read
// Steps the bus sequencer one tick or command item per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one
//   transaction per item: a 1 us tick, or a reset, write-byte or read-byte
//   command. Every accepted transaction yields exactly one result on the
//   output channel (o_out_valid / i_out_stall / o_out_data): drive level,
//   busy, done, last read byte and a rejected flag for commands given
//   while busy.
//   The result is registered and shows in the cycle after acceptance;
//   one transaction per clock while unstalled. The phase sequencer and
//   its tick counter update in the same cycle an item is accepted, so items
//   follow back to back. When the receiver stalls, the result register
//   holds it and o_in_stall rises; input resumes the cycle it is taken.
//   Configuration port (i_cfg_valid / o_cfg_ready) is always ready; write
//   only while the sequencer is idle.
//   Synchronous reset clears the sequencer to idle, the read byte to zero
//   and the timing registers to their defaults; no result is pending.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  owbm_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output owbm_pkg::t_out     o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import owbm_pkg::*;

    localparam int BIT_W = $clog2(BITS_PER_BYTE + 1);

    // Timing registers
    logic [15:0] r_pre_reset_high;
    logic [15:0] r_reset_low;
    logic [15:0] r_reset_wait;
    logic [15:0] r_slot;
    logic [7:0]  r_short;
    logic [15:0] r_post_write;

    // Sequencer state
    t_phase           r_phase,      n_phase;
    logic [15:0]      r_tick_count, n_tick_count;
    logic [BIT_W-1:0] r_bit_index,  n_bit_index;
    logic [7:0]       r_shift_byte, n_shift_byte;
    logic [1:0]       r_operation,  n_operation;
    logic [7:0]       r_read_latch, n_read_latch;

    // Result register
    logic r_out_valid;
    t_out r_out_data, n_out_data;

    logic             in_acc;
    logic             done;
    logic             rejected;
    logic [15:0]      slot_len;
    logic [15:0]      short_len;
    logic [15:0]      cur_len;
    logic [16:0]      tick_inc;
    logic [7:0]       shift_s;
    logic [BIT_W-1:0] bit_inc;
    t_phase           step_ph;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // Store timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_reset_high <= RST_PRE_RESET_HIGH;
            r_reset_low      <= RST_RESET_LOW;
            r_reset_wait     <= RST_RESET_WAIT;
            r_slot           <= RST_SLOT;
            r_short          <= RST_SHORT;
            r_post_write     <= RST_POST_WRITE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRE_RESET_HIGH: r_pre_reset_high <= i_cfg_data;
                CFG_RESET_LOW:      r_reset_low      <= i_cfg_data;
                CFG_RESET_WAIT:     r_reset_wait     <= i_cfg_data;
                CFG_SLOT:           r_slot           <= i_cfg_data;
                CFG_SHORT:          r_short          <= i_cfg_data[7:0];
                CFG_POST_WRITE:     r_post_write     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the low and slot lengths to at least one tick
    assign slot_len  = (r_slot == 16'd0) ? 16'd1 : r_slot;
    assign short_len = (r_short == 8'd0) ? 16'd1 : {8'd0, r_short};

    // Length of the current phase
    always_comb begin
        unique case (r_phase)
            PH_RST_PRE:  cur_len = r_pre_reset_high;
            PH_RST_LOW:  cur_len = (r_reset_low == 16'd0) ? 16'd1 : r_reset_low;
            PH_RST_WAIT: cur_len = r_reset_wait;
            PH_BIT_LOW:  cur_len = (r_operation == MODE_WRITE && !r_shift_byte[0])
                                   ? slot_len : short_len;
            PH_BIT_HIGH: begin
                if (r_operation == MODE_WRITE && !r_shift_byte[0]) begin
                    cur_len = short_len;
                end else begin
                    cur_len = slot_len;
                end
            end
            PH_GAP:      cur_len = r_post_write;
            default:     cur_len = 16'd0;
        endcase
    end

    assign tick_inc = {1'b0, r_tick_count} + 17'd1;
    assign bit_inc  = r_bit_index + BIT_W'(1);

    // Sample the line on the first released tick of a read slot
    always_comb begin
        shift_s = r_shift_byte;
        if (r_operation == MODE_READ && r_phase == PH_BIT_HIGH && r_tick_count == 16'd0) begin
            shift_s = {i_in_data.line_level, r_shift_byte[7:1]};
        end
    end

    // Next phase once the current one runs out, skipping empty released phases
    always_comb begin
        unique case (r_phase)
            PH_RST_PRE:  step_ph = PH_RST_LOW;
            PH_RST_LOW:  step_ph = (r_reset_wait == 16'd0) ? PH_IDLE : PH_RST_WAIT;
            PH_BIT_LOW:  step_ph = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
                if (bit_inc >= BIT_W'(BITS_PER_BYTE)) begin
                    if (r_operation == MODE_WRITE && r_post_write != 16'd0) begin
                        step_ph = PH_GAP;
                    end else begin
                        step_ph = PH_IDLE;
                    end
                end else begin
                    step_ph = PH_BIT_LOW;
                end
            end
            default:     step_ph = PH_IDLE;
        endcase
    end

    // Advance the sequencer for one transaction
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_operation  = r_operation;
        n_read_latch = r_read_latch;
        done         = 1'b0;
        rejected     = 1'b0;
        if (i_in_data.mode != MODE_TICK) begin
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_operation  = i_in_data.mode;
                n_bit_index  = '0;
                n_tick_count = 16'd0;
                if (i_in_data.mode == MODE_RESET) begin
                    n_phase = (r_pre_reset_high == 16'd0) ? PH_RST_LOW : PH_RST_PRE;
                end else begin
                    n_shift_byte = (i_in_data.mode == MODE_WRITE) ? i_in_data.data_byte
                                                                  : 8'd0;
                    n_phase      = PH_BIT_LOW;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_shift_byte = shift_s;
            if (tick_inc >= {1'b0, cur_len}) begin
                n_phase      = step_ph;
                n_tick_count = 16'd0;
                if (r_phase == PH_BIT_HIGH) begin
                    n_bit_index = bit_inc;
                    if (r_operation == MODE_WRITE) begin
                        n_shift_byte = {1'b0, shift_s[7:1]};
                    end
                end
                if (step_ph == PH_IDLE) begin
                    done = 1'b1;
                    if (r_operation == MODE_READ) begin
                        n_read_latch = shift_s;
                    end
                end
            end else begin
                n_tick_count = tick_inc[15:0];
            end
        end
    end

    // Build the result
    always_comb begin
        n_out_data.drive_low    = (n_phase == PH_RST_LOW) || (n_phase == PH_BIT_LOW);
        n_out_data.busy_res     = (n_phase != PH_IDLE);
        n_out_data.op_done      = done;
        n_out_data.read_data    = n_read_latch;
        n_out_data.cmd_rejected = rejected;
    end

    // Update state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= 16'd0;
            r_bit_index  <= '0;
            r_shift_byte <= 8'd0;
            r_operation  <= MODE_TICK;
            r_read_latch <= 8'd0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_operation  <= n_operation;
            r_read_latch <= n_read_latch;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.op_done && o_out_data.busy_res))
        else $error("operation done while still busy");

    a_drive_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.drive_low) |-> o_out_data.busy_res)
        else $error("bus driven low while idle");

    a_reject_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.cmd_rejected && o_out_data.op_done))
        else $error("rejected command reported as done");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode != MODE_TICK && r_phase != PH_IDLE)
        |=> ($stable(r_phase) && $stable(r_tick_count) && $stable(r_shift_byte)))
        else $error("rejected command changed sequencer state");

endmodule
